// ----- rtl/kbd_pkg.sv -----
// shared types, codes and keymap rom for the keyboard scancode decoder
// no dependencies; used by the channel interfaces and every rtl module
`default_nettype none

package kbd_pkg;

   // field widths of the request and response beats
   localparam int SCAN_W    = 8;
   localparam int POS_W     = 11;
   localparam int KIND_W    = 2;
   localparam int DATA_W    = 8;
   localparam int RSP_COL_W = 7;
   localparam int RSP_ROW_W = 5;
   localparam int MOD_W     = 3;

   // default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // keymap codes with a special meaning
   localparam logic [7:0] CODE_SHIFT  = 8'd176;
   localparam logic [7:0] CODE_ALT    = 8'd177;
   localparam logic [7:0] CODE_CTRL   = 8'd178;
   localparam logic [7:0] CODE_CAPS   = 8'd217;
   localparam logic [7:0] CODE_NUM    = 8'd218;
   localparam logic [7:0] CODE_SCROLL = 8'd219;
   localparam logic [7:0] CODE_UP     = 8'd24;
   localparam logic [7:0] CODE_DOWN   = 8'd25;
   localparam logic [7:0] CODE_RIGHT  = 8'd26;
   localparam logic [7:0] CODE_LEFT   = 8'd27;

   // raw scancode of the escape key, always a plain character
   localparam logic [7:0] SCAN_ESCAPE = 8'h01;

   // controller led command and its masks
   localparam logic [7:0] CMD_SET_LEDS = 8'hED;
   localparam logic [7:0] LED_CAPS     = 8'h04;
   localparam logic [7:0] LED_NUM      = 8'h02;
   localparam logic [7:0] LED_SCROLL   = 8'h01;

   // modifier bit positions
   localparam int MOD_SHIFT = 0;
   localparam int MOD_ALT   = 1;
   localparam int MOD_CTRL  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR = 2'd0,
      KIND_MOVE = 2'd1,
      KIND_CMD  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ACT_CHAR = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_LOCK = 2'd2
   } act_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   // decoded item held between the input register and the result register
   typedef struct packed {
      act_type           act;
      dir_type           dir;
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic [MOD_W-1:0]  mods;
   } s1_type;

   // spanish keymap: addr[7] selects the shifted half
   function automatic logic [7:0] keymap_byte(input logic [7:0] addr);
      logic [7:0] b;
      case (addr)
         8'd1,   8'd129: b = 8'd27;
         8'd2:   b = 8'd49;
         8'd3:   b = 8'd50;
         8'd4:   b = 8'd51;
         8'd5:   b = 8'd52;
         8'd6:   b = 8'd53;
         8'd7:   b = 8'd54;
         8'd8:   b = 8'd55;
         8'd9:   b = 8'd56;
         8'd10:  b = 8'd57;
         8'd11:  b = 8'd48;
         8'd12:  b = 8'd39;
         8'd13:  b = 8'd168;
         8'd14,  8'd142: b = 8'd8;
         8'd15,  8'd143: b = 8'd9;
         8'd16:  b = 8'd113;
         8'd17:  b = 8'd119;
         8'd18:  b = 8'd101;
         8'd19:  b = 8'd114;
         8'd20:  b = 8'd116;
         8'd21:  b = 8'd121;
         8'd22:  b = 8'd117;
         8'd23:  b = 8'd105;
         8'd24:  b = 8'd111;
         8'd25:  b = 8'd112;
         8'd27:  b = 8'd43;
         8'd28,  8'd156: b = 8'd10;
         8'd29,  8'd157: b = 8'd178;
         8'd30:  b = 8'd97;
         8'd31:  b = 8'd115;
         8'd32:  b = 8'd100;
         8'd33:  b = 8'd102;
         8'd34:  b = 8'd103;
         8'd35:  b = 8'd104;
         8'd36:  b = 8'd106;
         8'd37:  b = 8'd107;
         8'd38:  b = 8'd108;
         8'd39:  b = 8'd164;
         8'd40:  b = 8'd123;
         8'd41:  b = 8'd124;
         8'd42,  8'd170: b = 8'd176;
         8'd43:  b = 8'd125;
         8'd44:  b = 8'd122;
         8'd45:  b = 8'd120;
         8'd46:  b = 8'd99;
         8'd47:  b = 8'd118;
         8'd48:  b = 8'd98;
         8'd49:  b = 8'd110;
         8'd50:  b = 8'd109;
         8'd51:  b = 8'd44;
         8'd52:  b = 8'd46;
         8'd53:  b = 8'd45;
         8'd54,  8'd182: b = 8'd176;
         8'd55,  8'd183: b = 8'd42;
         8'd56,  8'd184: b = 8'd177;
         8'd57,  8'd185: b = 8'd32;
         8'd58,  8'd186: b = 8'd217;
         8'd69,  8'd197: b = 8'd218;
         8'd70,  8'd198: b = 8'd219;
         8'd72,  8'd200: b = 8'd24;
         8'd74,  8'd202: b = 8'd45;
         8'd75,  8'd203: b = 8'd27;
         8'd77,  8'd205: b = 8'd26;
         8'd78,  8'd206: b = 8'd43;
         8'd80,  8'd208: b = 8'd25;
         8'd86,  8'd214: b = 8'd60;
         // shifted half
         8'd130: b = 8'd33;
         8'd131: b = 8'd34;
         8'd132: b = 8'd35;
         8'd133: b = 8'd36;
         8'd134: b = 8'd37;
         8'd135: b = 8'd38;
         8'd136: b = 8'd47;
         8'd137: b = 8'd40;
         8'd138: b = 8'd41;
         8'd139: b = 8'd61;
         8'd140: b = 8'd63;
         8'd141: b = 8'd173;
         8'd144: b = 8'd81;
         8'd145: b = 8'd87;
         8'd146: b = 8'd69;
         8'd147: b = 8'd82;
         8'd148: b = 8'd84;
         8'd149: b = 8'd89;
         8'd150: b = 8'd85;
         8'd151: b = 8'd73;
         8'd152: b = 8'd79;
         8'd153: b = 8'd80;
         8'd155: b = 8'd42;
         8'd158: b = 8'd65;
         8'd159: b = 8'd83;
         8'd160: b = 8'd68;
         8'd161: b = 8'd70;
         8'd162: b = 8'd71;
         8'd163: b = 8'd72;
         8'd164: b = 8'd74;
         8'd165: b = 8'd75;
         8'd166: b = 8'd76;
         8'd167: b = 8'd165;
         8'd168: b = 8'd91;
         8'd169: b = 8'd167;
         8'd171: b = 8'd93;
         8'd172: b = 8'd90;
         8'd173: b = 8'd88;
         8'd174: b = 8'd67;
         8'd175: b = 8'd86;
         8'd176: b = 8'd66;
         8'd177: b = 8'd78;
         8'd178: b = 8'd77;
         8'd179: b = 8'd59;
         8'd180: b = 8'd58;
         8'd181: b = 8'd95;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/kbd_req_if.sv -----
// request channel: one scancode beat with the current cursor position
// depends on kbd_pkg for field widths
`default_nettype none

interface kbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [kbd_pkg::SCAN_W-1:0]   scancode;
   logic [kbd_pkg::POS_W-1:0]    cursor_position;

   modport source (output valid, scancode, cursor_position, input ready);
   modport sink   (input valid, scancode, cursor_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/kbd_rsp_if.sv -----
// response channel: one decoded result beat
// depends on kbd_pkg for field widths
`default_nettype none

interface kbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kbd_pkg::KIND_W-1:0]    kind;
   logic [kbd_pkg::DATA_W-1:0]    data_byte;
   logic [kbd_pkg::RSP_COL_W-1:0] cursor_column;
   logic [kbd_pkg::RSP_ROW_W-1:0] cursor_row;
   logic [kbd_pkg::MOD_W-1:0]     modifiers;
   logic                          last;

   modport source (output valid, kind, data_byte, cursor_column, cursor_row, modifiers, last,
                   input ready);
   modport sink   (input valid, kind, data_byte, cursor_column, cursor_row, modifiers, last,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/kbd_cursor.sv -----
// cursor move logic: splits the linear position and applies one arrow step
// depends on kbd_pkg; quotient comes precomputed from the input stage
`default_nettype none

module kbd_cursor #(
   parameter int  COLUMNS = kbd_pkg::COLUMNS_DEFAULT,
   parameter int  ROWS    = kbd_pkg::ROWS_DEFAULT,
   localparam int COL_W   = $clog2(COLUMNS),
   localparam int ROW_W   = $clog2(ROWS),
   localparam int QUO_W   = $clog2(((2 ** kbd_pkg::POS_W) - 1) / COLUMNS + 1)
) (
   input  wire logic [kbd_pkg::POS_W-1:0] pos,
   input  wire logic [QUO_W-1:0]          quo,
   input  wire kbd_pkg::dir_type          dir,
   output logic      [COL_W-1:0]          col,
   output logic      [ROW_W-1:0]          row
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [kbd_pkg::POS_W-1:0] prod;
   logic [kbd_pkg::POS_W-1:0] rem;
   logic [kbd_pkg::POS_W-1:0] quo_x;
   logic [COL_W-1:0]          col_cur;
   logic [ROW_W-1:0]          row_cur;

   // remainder from the quotient, row clamped to the last row
   always_comb begin
      prod    = kbd_pkg::POS_W'(quo * COLUMNS);
      rem     = pos - prod;
      col_cur = COL_W'(rem);
      quo_x   = kbd_pkg::POS_W'(quo);
      row_cur = (quo_x > kbd_pkg::POS_W'(ROWS - 1)) ? LAST_ROW : ROW_W'(quo);
   end

   // one arrow step
   always_comb begin
      col = col_cur;
      row = row_cur;
      case (dir)
         kbd_pkg::DIR_UP: begin
            if (row_cur != '0) row = row_cur - 1'b1;
         end
         kbd_pkg::DIR_DOWN: begin
            if (row_cur < LAST_ROW) row = row_cur + 1'b1;
         end
         kbd_pkg::DIR_RIGHT: begin
            if (col_cur < LAST_COL) begin
               col = col_cur + 1'b1;
            end else begin
               col = '0;
               if (row_cur < LAST_ROW) row = row_cur + 1'b1;
            end
         end
         kbd_pkg::DIR_LEFT: begin
            if (col_cur != '0) col = col_cur - 1'b1;
            else if (row_cur != '0) row = row_cur - 1'b1;
         end
         default: begin
            col = col_cur;
            row = row_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/keyboard_scancode_decoder.sv -----
// a scancode beat is registered in the input stage, then its result beat in the result register
// one scancode per cycle while the result register is free; lock keys hold the result
//   register for two beats (command then led mask), holding off new scancodes meanwhile
// reset clears the modifier bits and empties both registers; no clearing pass
// depends on kbd_pkg, kbd_req_if, kbd_rsp_if and kbd_cursor
`default_nettype none

module keyboard_scancode_decoder #(
   parameter int COLUMNS = kbd_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = kbd_pkg::ROWS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   kbd_req_if.sink   req,
   kbd_rsp_if.source rsp
);

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int POS_MAX = (2 ** kbd_pkg::POS_W) - 1;
   localparam int QUO_W   = $clog2(POS_MAX / COLUMNS + 1);
   // exact reciprocal for every 11-bit position
   localparam int SHIFT   = kbd_pkg::POS_W + $clog2(COLUMNS);
   localparam int RECIP   = ((2 ** SHIFT) + COLUMNS - 1) / COLUMNS;
   localparam int RCP_W   = $clog2(RECIP + 1);
   localparam int PRD_W   = kbd_pkg::POS_W + RCP_W;

   // modifier state and input stage
   logic [kbd_pkg::MOD_W-1:0] mods_ff, mods_in;
   logic                      s1_valid_ff, s1_valid_in;
   kbd_pkg::s1_type           s1_ff, s1_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pend_ff, pend_in;
   kbd_pkg::kind_type             kind_ff, kind_in;
   logic [kbd_pkg::DATA_W-1:0]    data_ff, data_in;
   logic [kbd_pkg::DATA_W-1:0]    mask_ff, mask_in;
   logic [kbd_pkg::RSP_COL_W-1:0] col_ff, col_in;
   logic [kbd_pkg::RSP_ROW_W-1:0] row_ff, row_in;
   logic [kbd_pkg::MOD_W-1:0]     omods_ff, omods_in;
   logic                          last_ff, last_in;

   logic                       req_fire, rsp_fire, out_free, s1_adv;
   logic [7:0]                 entry, entry_eff, chr;
   logic                       emits;
   logic [PRD_W-1:0]           prod;
   logic [COL_W-1:0]           move_col;
   logic [ROW_W-1:0]           move_row;

   // handshake
   assign rsp_fire  = rsp_valid_ff && rsp.ready;
   assign out_free  = !pend_ff && (!rsp_valid_ff || rsp.ready);
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   // keymap lookups and reciprocal divide on the incoming beat
   always_comb begin
      entry     = kbd_pkg::keymap_byte({1'b0, req.scancode[6:0]});
      chr       = kbd_pkg::keymap_byte({mods_ff[kbd_pkg::MOD_SHIFT], req.scancode[6:0]});
      entry_eff = (req.scancode == kbd_pkg::SCAN_ESCAPE) ? 8'd0 : entry;
      prod      = PRD_W'(req.cursor_position) * PRD_W'(RECIP);
      quo_in    = QUO_W'(prod >> SHIFT);
   end

   // decode: modifier update and the action to carry forward
   always_comb begin
      mods_in      = mods_ff;
      emits        = 1'b0;
      s1_in        = s1_ff;
      s1_in.act    = kbd_pkg::ACT_CHAR;
      s1_in.dir    = kbd_pkg::DIR_UP;
      s1_in.data   = chr;
      s1_in.pos    = req.cursor_position;
      if (req.scancode[7]) begin
         case (entry)
            kbd_pkg::CODE_SHIFT: mods_in[kbd_pkg::MOD_SHIFT] = 1'b0;
            kbd_pkg::CODE_ALT:   mods_in[kbd_pkg::MOD_ALT]   = 1'b0;
            kbd_pkg::CODE_CTRL:  mods_in[kbd_pkg::MOD_CTRL]  = 1'b0;
            default:             mods_in = mods_ff;
         endcase
      end else begin
         emits = 1'b1;
         case (entry_eff)
            kbd_pkg::CODE_SHIFT: begin
               mods_in[kbd_pkg::MOD_SHIFT] = 1'b1;
               emits = 1'b0;
            end
            kbd_pkg::CODE_ALT: begin
               mods_in[kbd_pkg::MOD_ALT] = 1'b1;
               emits = 1'b0;
            end
            kbd_pkg::CODE_CTRL: begin
               mods_in[kbd_pkg::MOD_CTRL] = 1'b1;
               emits = 1'b0;
            end
            kbd_pkg::CODE_CAPS: begin
               s1_in.act  = kbd_pkg::ACT_LOCK;
               s1_in.data = kbd_pkg::LED_CAPS;
            end
            kbd_pkg::CODE_NUM: begin
               s1_in.act  = kbd_pkg::ACT_LOCK;
               s1_in.data = kbd_pkg::LED_NUM;
            end
            kbd_pkg::CODE_SCROLL: begin
               s1_in.act  = kbd_pkg::ACT_LOCK;
               s1_in.data = kbd_pkg::LED_SCROLL;
            end
            kbd_pkg::CODE_UP: begin
               s1_in.act = kbd_pkg::ACT_MOVE;
               s1_in.dir = kbd_pkg::DIR_UP;
            end
            kbd_pkg::CODE_DOWN: begin
               s1_in.act = kbd_pkg::ACT_MOVE;
               s1_in.dir = kbd_pkg::DIR_DOWN;
            end
            kbd_pkg::CODE_RIGHT: begin
               s1_in.act = kbd_pkg::ACT_MOVE;
               s1_in.dir = kbd_pkg::DIR_RIGHT;
            end
            kbd_pkg::CODE_LEFT: begin
               s1_in.act = kbd_pkg::ACT_MOVE;
               s1_in.dir = kbd_pkg::DIR_LEFT;
            end
            default: s1_in.act = kbd_pkg::ACT_CHAR;
         endcase
      end
      s1_in.mods  = mods_in;
      s1_valid_in = req_fire ? emits : (s1_valid_ff && !s1_adv);
   end

   // cursor arithmetic between the two registers
   kbd_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .pos (s1_ff.pos),
      .quo (quo_ff),
      .dir (s1_ff.dir),
      .col (move_col),
      .row (move_row)
   );

   // result register load: new item, second lock beat, clear when taken, or hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      mask_in      = mask_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      omods_in     = omods_ff;
      last_in      = last_ff;
      if (pend_ff && rsp_fire) begin
         data_in = mask_ff;
         last_in = 1'b1;
         pend_in = 1'b0;
      end else if (s1_adv) begin
         rsp_valid_in = 1'b1;
         omods_in     = s1_ff.mods;
         col_in       = '0;
         row_in       = '0;
         last_in      = 1'b1;
         pend_in      = 1'b0;
         case (s1_ff.act)
            kbd_pkg::ACT_MOVE: begin
               kind_in = kbd_pkg::KIND_MOVE;
               data_in = '0;
               col_in  = kbd_pkg::RSP_COL_W'(move_col);
               row_in  = kbd_pkg::RSP_ROW_W'(move_row);
            end
            kbd_pkg::ACT_LOCK: begin
               kind_in = kbd_pkg::KIND_CMD;
               data_in = kbd_pkg::CMD_SET_LEDS;
               mask_in = s1_ff.data;
               last_in = 1'b0;
               pend_in = 1'b1;
            end
            default: begin
               kind_in = kbd_pkg::KIND_CHAR;
               data_in = s1_ff.data;
            end
         endcase
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (req_fire) mods_ff <= mods_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff  <= s1_in;
         quo_ff <= quo_in;
      end
      kind_ff  <= kind_in;
      data_ff  <= data_in;
      mask_ff  <= mask_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      omods_ff <= omods_in;
      last_ff  <= last_in;
   end

   // response beat
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.data_byte     = data_ff;
   assign rsp.cursor_column = col_ff;
   assign rsp.cursor_row    = row_ff;
   assign rsp.modifiers     = omods_ff;
   assign rsp.last          = last_ff;

   // a pending led mask always sits behind a shown command beat
   a_pend_valid : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_valid_ff)
      else $error("led mask pending without a shown beat");

   // taking the command beat brings the final led mask beat next
   a_lock_second : assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp.ready) |=>
         (rsp.valid && rsp.last && rsp.kind == kbd_pkg::KIND_CMD))
      else $error("lock key second beat missing");

   // a non-final beat only comes from a lock key with its mask waiting
   a_nonlast_lock : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.last) |-> (pend_ff && rsp.kind == kbd_pkg::KIND_CMD))
      else $error("non-final beat outside a lock key sequence");

endmodule

`default_nettype wire

// ----- tb/sv/kbd_decoder_checker.sv -----
// scoreboard for the keyboard scancode decoder: watches both channels,
// predicts every result beat and compares it field by field
// depends on kbd_pkg, kbd_req_if and kbd_rsp_if
module kbd_decoder_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic clock,
   input  logic reset,
   kbd_req_if   req,
   kbd_rsp_if   rsp,
   output int   fail_count,
   output int   results_pending,
   output int   results_checked
);
   import kbd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type               kind;
      logic [DATA_W-1:0]      data;
      logic [RSP_COL_W-1:0]   col;
      logic [RSP_ROW_W-1:0]   row;
      logic [MOD_W-1:0]       mods;
      logic                   last;
   } key_result_type;

   key_result_type   decoded_due[$];
   logic [MOD_W-1:0] held_mods;
   int               errors;
   int               checked;

   // spanish layout, normal half unless shifted is set
   function automatic logic [7:0] keymap_lookup(input logic [6:0] idx, input logic shifted);
      logic [7:0] b;
      case (idx)
         1:  b = 8'd27;
         2:  b = shifted ? "!" : "1";
         3:  b = shifted ? 8'd34 : "2";
         4:  b = shifted ? "#" : "3";
         5:  b = shifted ? "$" : "4";
         6:  b = shifted ? "%" : "5";
         7:  b = shifted ? "&" : "6";
         8:  b = shifted ? "/" : "7";
         9:  b = shifted ? "(" : "8";
         10: b = shifted ? ")" : "9";
         11: b = shifted ? "=" : "0";
         12: b = shifted ? "?" : 8'd39;
         13: b = shifted ? 8'd173 : 8'd168;
         14: b = 8'd8;
         15: b = 8'd9;
         16: b = "q";
         17: b = "w";
         18: b = "e";
         19: b = "r";
         20: b = "t";
         21: b = "y";
         22: b = "u";
         23: b = "i";
         24: b = "o";
         25: b = "p";
         27: b = shifted ? "*" : "+";
         28: b = 8'd10;
         29: b = 8'd178;
         30: b = "a";
         31: b = "s";
         32: b = "d";
         33: b = "f";
         34: b = "g";
         35: b = "h";
         36: b = "j";
         37: b = "k";
         38: b = "l";
         39: b = shifted ? 8'd165 : 8'd164;
         40: b = shifted ? "[" : "{";
         41: b = shifted ? 8'd167 : "|";
         42: b = 8'd176;
         43: b = shifted ? "]" : "}";
         44: b = "z";
         45: b = "x";
         46: b = "c";
         47: b = "v";
         48: b = "b";
         49: b = "n";
         50: b = "m";
         51: b = shifted ? ";" : ",";
         52: b = shifted ? ":" : ".";
         53: b = shifted ? "_" : "-";
         54: b = 8'd176;
         55: b = "*";
         56: b = 8'd177;
         57: b = " ";
         58: b = 8'd217;
         69: b = 8'd218;
         70: b = 8'd219;
         72: b = 8'd24;
         74: b = "-";
         75: b = 8'd27;
         77: b = 8'd26;
         78: b = "+";
         80: b = 8'd25;
         86: b = "<";
         default: b = 8'd0;
      endcase
      // letters use the upper case in the shifted half
      if (shifted && b >= "a" && b <= "z") begin
         b = b - 8'd32;
      end
      return b;
   endfunction

   // update the held modifiers and queue the beats one scancode causes
   task automatic decode_key(input logic [SCAN_W-1:0] code, input logic [POS_W-1:0] pos);
      logic [7:0]     entry;
      int             col;
      int             row;
      key_result_type r;
      entry = keymap_lookup(code[6:0], 1'b0);
      // release: only modifiers react, and never with a beat
      if (code[7]) begin
         case (entry)
            CODE_SHIFT: held_mods[MOD_SHIFT] = 1'b0;
            CODE_ALT:   held_mods[MOD_ALT]   = 1'b0;
            CODE_CTRL:  held_mods[MOD_CTRL]  = 1'b0;
            default: ;
         endcase
         return;
      end
      // escape shares its keymap byte with the left arrow but is a character
      if (code == SCAN_ESCAPE) begin
         entry = 8'd0;
      end
      r = '0;
      r.last = 1'b1;
      case (entry)
         CODE_SHIFT: held_mods[MOD_SHIFT] = 1'b1;
         CODE_ALT:   held_mods[MOD_ALT]   = 1'b1;
         CODE_CTRL:  held_mods[MOD_CTRL]  = 1'b1;
         CODE_CAPS, CODE_NUM, CODE_SCROLL: begin
            r.kind = KIND_CMD;
            r.mods = held_mods;
            r.data = CMD_SET_LEDS;
            r.last = 1'b0;
            decoded_due.push_back(r);
            r.data = (entry == CODE_CAPS) ? LED_CAPS : (entry == CODE_NUM) ? LED_NUM : LED_SCROLL;
            r.last = 1'b1;
            decoded_due.push_back(r);
         end
         CODE_UP, CODE_DOWN, CODE_RIGHT, CODE_LEFT: begin
            col = int'(pos) % COLUMNS;
            row = int'(pos) / COLUMNS;
            if (row > ROWS - 1) begin
               row = ROWS - 1;
            end
            case (entry)
               CODE_UP: begin
                  if (row > 0) row--;
               end
               CODE_DOWN: begin
                  if (row < ROWS - 1) row++;
               end
               CODE_RIGHT: begin
                  if (col < COLUMNS - 1) begin
                     col++;
                  end else begin
                     col = 0;
                     if (row < ROWS - 1) row++;
                  end
               end
               default: begin
                  if (col > 0) col--;
                  else if (row > 0) row--;
               end
            endcase
            r.kind = KIND_MOVE;
            r.col  = col[RSP_COL_W-1:0];
            r.row  = row[RSP_ROW_W-1:0];
            r.mods = held_mods;
            decoded_due.push_back(r);
         end
         default: begin
            r.kind = KIND_CHAR;
            r.data = keymap_lookup(code[6:0], held_mods[MOD_SHIFT]);
            r.mods = held_mods;
            decoded_due.push_back(r);
         end
      endcase
   endtask

   // sample both channels at the edge, predict first, then compare
   always @(posedge clock) begin
      key_result_type seen;
      key_result_type want;
      if (reset) begin
         decoded_due.delete();
         held_mods = '0;
         errors    = 0;
         checked   = 0;
      end else begin
         if (req.valid && req.ready) begin
            decode_key(req.scancode, req.cursor_position);
         end
         if (rsp.valid && rsp.ready) begin
            seen.kind = kind_type'(rsp.kind);
            seen.data = rsp.data_byte;
            seen.col  = rsp.cursor_column;
            seen.row  = rsp.cursor_row;
            seen.mods = rsp.modifiers;
            seen.last = rsp.last;
            checked++;
            if (decoded_due.size() == 0) begin
               if (errors < REPORT_LIMIT) begin
                  $display("unexpected beat: kind=%0d data=%02h col=%0d row=%0d mods=%b last=%b",
                           seen.kind, seen.data, seen.col, seen.row, seen.mods, seen.last);
               end
               errors++;
            end else begin
               want = decoded_due.pop_front();
               if (want != seen) begin
                  if (errors < REPORT_LIMIT) begin
                     $display("mismatch: expected kind=%0d data=%02h col=%0d row=%0d mods=%b last=%b",
                              want.kind, want.data, want.col, want.row, want.mods, want.last);
                     $display("          actual   kind=%0d data=%02h col=%0d row=%0d mods=%b last=%b",
                              seen.kind, seen.data, seen.col, seen.row, seen.mods, seen.last);
                  end
                  errors++;
               end
            end
         end
      end
      fail_count      <= errors;
      results_pending <= decoded_due.size();
      results_checked <= checked;
   end

endmodule

// ----- tb/sv/tb_keyboard_scancode_decoder.sv -----
// top of the keyboard scancode decoder testbench: clock, reset, scancode
// stimulus, result back-pressure, watchdog and verdict
// depends on kbd_pkg, kbd_req_if, kbd_rsp_if, kbd_decoder_checker and the rtl
module tb_keyboard_scancode_decoder;
   import kbd_pkg::*;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int POS_MAX        = (1 << POS_W) - 1;
   localparam int ITEM_TARGET    = 1400;
   localparam int MAX_GAP        = 4;
   localparam int HOLD_CYCLES    = 80;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // raw set-1 scancodes used by name
   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [7:0] SC_LSHIFT   = 8'h2A;
   localparam logic [7:0] SC_RSHIFT   = 8'h36;
   localparam logic [7:0] SC_ALT      = 8'h38;
   localparam logic [7:0] SC_CTRL     = 8'h1D;
   localparam logic [7:0] SC_CAPS     = 8'h3A;
   localparam logic [7:0] SC_NUM      = 8'h45;
   localparam logic [7:0] SC_SCROLL   = 8'h46;
   localparam logic [7:0] SC_UP       = 8'h48;
   localparam logic [7:0] SC_DOWN     = 8'h50;
   localparam logic [7:0] SC_RIGHT    = 8'h4D;
   localparam logic [7:0] SC_LEFT     = 8'h4B;
   localparam logic [7:0] SC_KEY_Q    = 8'h10;
   localparam logic [7:0] SC_KEY_A    = 8'h1E;
   localparam logic [7:0] SC_KEY_1    = 8'h02;
   localparam logic [7:0] SC_NONE     = 8'h00;
   localparam logic [7:0] SC_TOP      = 8'h7F;
   localparam logic [7:0] SC_ALL_ONES = 8'hFF;

   logic clock = 1'b0;
   logic reset;

   kbd_req_if req_ch();
   kbd_rsp_if rsp_ch();

   int fail_count;
   int results_pending;
   int results_checked;
   int beats_sent;
   int presses;
   bit steady;
   bit rsp_hold;

   always #10 clock = ~clock;

   keyboard_scancode_decoder #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   kbd_decoder_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   // offer one scancode beat, after a random gap unless steady, and wait for its acceptance
   task automatic send_key(input logic [7:0] code, input logic [POS_W-1:0] pos);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.scancode        <= code;
      req_ch.cursor_position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      if (!code[7]) presses++;
   endtask

   // stop offering and wait until every predicted beat has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] any_position();
      return POS_W'($urandom_range(0, POS_MAX));
   endfunction

   // cursor positions biased toward the grid edges and past the last row
   function automatic logic [POS_W-1:0] cursor_spot();
      int col;
      int row;
      case ($urandom_range(0, 5))
         0: col = 0;
         1: col = COLUMNS - 1;
         default: col = $urandom_range(0, COLUMNS - 1);
      endcase
      case ($urandom_range(0, 6))
         0: row = 0;
         1: row = ROWS - 1;
         2: row = ROWS;
         default: row = $urandom_range(0, ROWS - 1);
      endcase
      if (row == ROWS) return POS_W'($urandom_range(COLUMNS * ROWS, POS_MAX));
      return POS_W'(row * COLUMNS + col);
   endfunction

   function automatic logic [7:0] modifier_key();
      case ($urandom_range(0, 3))
         0: return SC_LSHIFT;
         1: return SC_RSHIFT;
         2: return SC_ALT;
         default: return SC_CTRL;
      endcase
   endfunction

   function automatic logic [7:0] lock_key();
      case ($urandom_range(0, 2))
         0: return SC_CAPS;
         1: return SC_NUM;
         default: return SC_SCROLL;
      endcase
   endfunction

   function automatic logic [7:0] arrow_key();
      case ($urandom_range(0, 3))
         0: return SC_UP;
         1: return SC_DOWN;
         2: return SC_RIGHT;
         default: return SC_LEFT;
      endcase
   endfunction

   // mostly the main block of mapped keys, sometimes anything in the press range
   function automatic logic [7:0] typing_key();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 127));
      return 8'($urandom_range(1, 58));
   endfunction

   // result side: random ready gaps, plus one long hold-off on request
   initial begin
      int gap;
      forever begin
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // watchdog on cycles without any beat on either channel
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, results_pending);
      $display("Regression FAIL");
      $finish;
   end

   // stimulus and verdict
   initial begin
      logic [7:0] held;
      logic [7:0] key;
      bit         pressure_done;
      bit         pause_done;
      int         n;
      beats_sent    = 0;
      presses       = 0;
      steady        = 1'b1;
      rsp_hold      = 1'b0;
      pressure_done = 1'b0;
      pause_done    = 1'b0;
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.scancode        <= '0;
      req_ch.cursor_position <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: escape, unmapped codes, modifiers, locks and cursor edges
      send_key(SCAN_ESCAPE, 11'd0);
      send_key(SC_NONE, 11'd0);
      send_key(SC_TOP, POS_W'(POS_MAX));
      send_key(SC_ALL_ONES, POS_W'(POS_MAX));
      send_key(SC_LSHIFT, 11'd5);
      send_key(SC_KEY_Q, 11'd5);
      send_key(SC_KEY_1, 11'd5);
      send_key(SC_LSHIFT | RELEASE_BIT, 11'd5);
      send_key(SC_ALT, 11'd5);
      send_key(SC_CTRL, 11'd5);
      send_key(SC_KEY_A, 11'd5);
      send_key(SC_ALT | RELEASE_BIT, 11'd5);
      send_key(SC_CAPS, 11'd0);
      send_key(SC_CTRL | RELEASE_BIT, 11'd5);
      send_key(SC_NUM, 11'd0);
      send_key(SC_SCROLL, 11'd0);
      send_key(SC_UP, 11'd0);
      send_key(SC_DOWN, 11'd1999);
      send_key(SC_RIGHT, 11'd1999);
      send_key(SC_RIGHT, 11'd79);
      send_key(SC_LEFT, 11'd0);
      send_key(SC_LEFT, 11'd80);
      send_key(SC_UP, POS_W'(POS_MAX));
      send_key(SC_RSHIFT, 11'd0);
      send_key(SC_RSHIFT | RELEASE_BIT, 11'd0);
      wait_for_drain();
      steady = 1'b0;

      // random: mostly well-formed typing, some moves, locks and raw noise
      while (beats_sent < ITEM_TARGET) begin
         if (!pressure_done && beats_sent >= 500) begin
            // results held back while lock keys keep coming
            rsp_hold = 1'b1;
            steady   = 1'b1;
            repeat (12) send_key(lock_key(), any_position());
            steady        = 1'b0;
            pressure_done = 1'b1;
         end
         if (!pause_done && beats_sent >= 900) begin
            wait_for_drain();
            pause_done = 1'b1;
         end
         if ($urandom_range(0, 15) == 0) steady = !steady;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               held = ($urandom_range(0, 1) == 1) ? modifier_key() : SC_NONE;
               if (held != SC_NONE) send_key(held, any_position());
               n = $urandom_range(1, 4);
               repeat (n) begin
                  key = typing_key();
                  send_key(key, any_position());
                  if ($urandom_range(0, 3) != 0) send_key(key | RELEASE_BIT, any_position());
               end
               // now and then a modifier is left held
               if (held != SC_NONE && $urandom_range(0, 9) != 0) begin
                  send_key(held | RELEASE_BIT, any_position());
               end
            end
            11, 12, 13: begin
               key = arrow_key();
               send_key(key, cursor_spot());
               send_key(key | RELEASE_BIT, cursor_spot());
            end
            14, 15: begin
               key = lock_key();
               send_key(key, any_position());
               send_key(key | RELEASE_BIT, any_position());
            end
            default: send_key(8'($urandom_range(0, 255)), any_position());
         endcase
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d scancode beats, %0d key presses with modifiers, locks,",
               beats_sent, presses);
      $display("arrows and noise; %0d result beats compared, %0d failures",
               results_checked, fail_count);
      if (fail_count == 0 && results_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/kbd_pkg.sv
rtl/kbd_req_if.sv
rtl/kbd_rsp_if.sv
rtl/kbd_cursor.sv
rtl/keyboard_scancode_decoder.sv
tb/sv/kbd_decoder_checker.sv
tb/sv/tb_keyboard_scancode_decoder.sv
